### sv/qpwa_pkg.sv
// Shared types and constants for the quadrature pair window analyser.
// Used by the top level and the shared arithmetic units; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qpwa_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SXY, S_NN, S_CXD, S_CYD,
    S_AXA, S_AXB, S_AXD, S_AXS, S_AYA, S_AYB, S_AYD, S_AYS,
    S_VERD, S_LGI, S_LGS, S_BAL,
    S_PHA, S_PHB, S_PHC, S_PHD, S_PHE, S_PHF, S_PHG, S_PHH, S_FIN
  } state_t;

  localparam logic [1:0] VERDICT_SILENT   = 2'd0;
  localparam logic [1:0] VERDICT_SLOW     = 2'd1;
  localparam logic [1:0] VERDICT_MEASURED = 2'd2;

  localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SILENCE_FLOOR  = 2'd1;
  localparam logic [1:0] REG_MIN_HALF_TURNS = 2'd2;

  localparam logic [18:0] BAL_K     = 19'd394566;
  localparam logic [15:0] PHASE_MAX = 16'd23040;
  localparam int          OUT_W     = 152;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic        neg;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] v;
  } sqrt_req_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] x0;
    logic signed [33:0] y0;
  } cordic_req_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [31:0] atan_deg(input logic [3:0] i);
    logic signed [31:0] v;
    case (i)
      4'd0:    v = 32'sd2949120;
      4'd1:    v = 32'sd1740967;
      4'd2:    v = 32'sd919879;
      4'd3:    v = 32'sd466945;
      4'd4:    v = 32'sd234379;
      4'd5:    v = 32'sd117304;
      4'd6:    v = 32'sd58666;
      4'd7:    v = 32'sd29335;
      4'd8:    v = 32'sd14668;
      4'd9:    v = 32'sd7334;
      4'd10:   v = 32'sd3667;
      4'd11:   v = 32'sd1833;
      4'd12:   v = 32'sd917;
      4'd13:   v = 32'sd458;
      4'd14:   v = 32'sd229;
      4'd15:   v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/qpwa_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, product mod 2^64.
// Sign applied at the end; uses qpwa_pkg::mul_req_t.
`timescale 1ns / 1ps
`default_nettype none
module qpwa_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire qpwa_pkg::mul_req_t req,
  output logic                  done,
  output logic [63:0]           res
);
  logic        busy_r, done_r, neg_r;
  logic [63:0] acc_r, aa_r, bb_r, res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bb_r == 64'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= 64'd0;
      aa_r  <= req.a;
      bb_r  <= req.b;
      neg_r <= req.neg;
    end else if (busy_r) begin
      if (bb_r == 64'd0) begin
        res_r <= neg_r ? (64'd0 - acc_r) : acc_r;
      end else begin
        if (bb_r[0]) acc_r <= acc_r + aa_r;
        aa_r <= {aa_r[62:0], 1'b0};
        bb_r <= {1'b0, bb_r[63:1]};
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

### sv/qpwa_div.sv
// Restoring unsigned 64/64 divider, one quotient bit per cycle.
// Uses qpwa_pkg::div_req_t.
`timescale 1ns / 1ps
`default_nettype none
module qpwa_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire qpwa_pkg::div_req_t req,
  output logic                  done,
  output logic [63:0]           res
);
  logic        busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [64:0] rem_r;
  logic [63:0] quo_r, den_r;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r[63:0], quo_r[63]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 65'd0;
      quo_r <= req.num;
      den_r <= req.den;
      cnt_r <= 7'd64;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[62:0], fits};
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign done = done_r;
  assign res  = quo_r;
endmodule
`default_nettype wire

### sv/qpwa_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle (32 steps).
// Uses qpwa_pkg::sqrt_req_t.
`timescale 1ns / 1ps
`default_nettype none
module qpwa_sqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qpwa_pkg::sqrt_req_t req,
  output logic                   done,
  output logic [31:0]            res
);
  logic        busy_r, done_r;
  logic [63:0] v_r, root_r, bit_r;
  logic [63:0] trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 64'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v_r    <= req.v;
      root_r <= 64'd0;
      bit_r  <= 64'h4000_0000_0000_0000;
    end else if (busy_r && bit_r != 64'd0) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= {1'b0, root_r[63:1]} + bit_r;
      end else begin
        root_r <= {1'b0, root_r[63:1]};
      end
      bit_r <= {2'b00, bit_r[63:2]};
    end
  end

  assign done = done_r;
  assign res  = root_r[31:0];
endmodule
`default_nettype wire

### sv/qpwa_cordic.sv
// Vectoring CORDIC, 16 iterations, angle accumulated in degrees Q16.
// Uses qpwa_pkg::cordic_req_t and the qpwa_pkg::atan_deg table.
`timescale 1ns / 1ps
`default_nettype none
module qpwa_cordic (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qpwa_pkg::cordic_req_t req,
  output logic                     done,
  output logic signed [31:0]       angle
);
  logic               busy_r, done_r;
  logic [3:0]         i_r;
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic signed [33:0] xs, ys;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == 4'd15) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= req.x0;
      y_r <= req.y0;
      z_r <= 32'sd0;
      i_r <= 4'd0;
    end else if (busy_r) begin
      if (y_r > 34'sd0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + qpwa_pkg::atan_deg(i_r);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - qpwa_pkg::atan_deg(i_r);
      end
      i_r <= i_r + 4'd1;
    end
  end

  assign done  = done_r;
  assign angle = z_r;
endmodule
`default_nettype wire

### sv/quadrature_pair_window_analyser_unit.sv
// Quadrature pair window analyser: accumulates x/y statistics per window and
// emits centres, amplitudes, half turns, verdict, balance (dB) and phase (deg).
// Frames are taken one at a time, only in the idle state: each is folded in by three
// shift-add products, one magnitude bit per cycle, before the next is accepted. A reading
// is computed after the closing frame on the shared multiplier, 64-step divider and 32-step root, plus stalls.
// Reset (rst_n low, synchronous) clears sums, counters and control; config to defaults.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_pair_window_analyser_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,  // sample_x[15:0], sample_y[31:16]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // mean_x, mean_y, peak_x, peak_y, half_turns (16 each),
  // window_number (32), verdict (2), level_ratio (16), skew_angle (16), pad
  output logic [qpwa_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [15:0]                cfg_data
);
  qpwa_pkg::state_t state_r, state_nxt;
  logic launched_r, launched_nxt;

  logic [15:0] wl_r, sf_r, mht_r;

  logic signed [15:0] x_r, x_nxt, y_r, y_nxt, level_r, level_nxt;
  logic [31:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [47:0] sq_x_r, sq_x_nxt, sq_y_r, sq_y_nxt, cross_r, cross_nxt;
  logic [15:0] fc_r, fc_nxt, cc_r, cc_nxt;
  logic        was_above_r, was_above_nxt, have_prev_r, have_prev_nxt;
  logic        pub_r, pub_nxt;
  logic [31:0] wtot_r, wtot_nxt;

  logic [31:0] nn_r, nn_nxt;
  logic [63:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic [15:0] cx_r, cx_nxt, cy_r, cy_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic [1:0]  verdict_r, verdict_nxt;
  logic [15:0] bal_r, bal_nxt, ph_r, ph_nxt;
  logic        neg_r, neg_nxt;
  logic [16:0] s_r, s_nxt;
  logic [31:0] lg_m_r, lg_m_nxt;
  logic [19:0] lg_acc_r, lg_acc_nxt, lg_y_r, lg_y_nxt;
  logic [3:0]  lg_i_r, lg_i_nxt;
  logic        lg_sel_r, lg_sel_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [qpwa_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  qpwa_pkg::mul_req_t    mul_req;
  qpwa_pkg::div_req_t    div_req;
  qpwa_pkg::sqrt_req_t   sqrt_req;
  qpwa_pkg::cordic_req_t cor_req;
  logic        mul_done, div_done, sqrt_done, cor_done;
  logic [63:0] mul_res, div_res;
  logic [31:0] sqrt_res;
  logic signed [31:0] cor_angle;

  logic [15:0] xm, ym;
  logic [31:0] mx, my;
  logic [47:0] cmag;

  assign xm   = x_r[15] ? 16'(-x_r) : x_r;
  assign ym   = y_r[15] ? 16'(-y_r) : y_r;
  assign mx   = sum_x_r[31] ? (32'd0 - sum_x_r) : sum_x_r;
  assign my   = sum_y_r[31] ? (32'd0 - sum_y_r) : sum_y_r;
  assign cmag = cross_r[47] ? (48'd0 - cross_r) : cross_r;

  qpwa_mul    u_mul  (.clk, .rst_n, .req(mul_req),  .done(mul_done),  .res(mul_res));
  qpwa_div    u_div  (.clk, .rst_n, .req(div_req),  .done(div_done),  .res(div_res));
  qpwa_sqrt   u_sqrt (.clk, .rst_n, .req(sqrt_req), .done(sqrt_done), .res(sqrt_res));
  qpwa_cordic u_cor  (.clk, .rst_n, .req(cor_req),  .done(cor_done),  .angle(cor_angle));

  assign in_tready  = (state_r == qpwa_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= 16'd4096;
      sf_r  <= 16'd328;
      mht_r <= 16'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        qpwa_pkg::REG_WINDOW_LENGTH:  wl_r  <= cfg_data;
        qpwa_pkg::REG_SILENCE_FLOOR:  sf_r  <= cfg_data;
        qpwa_pkg::REG_MIN_HALF_TURNS: mht_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qpwa_pkg::S_IDLE;
      launched_r  <= 1'b0;
      sum_x_r     <= 32'd0;
      sum_y_r     <= 32'd0;
      sq_x_r      <= 48'd0;
      sq_y_r      <= 48'd0;
      cross_r     <= 48'd0;
      fc_r        <= 16'd0;
      cc_r        <= 16'd0;
      level_r     <= 16'sd0;
      was_above_r <= 1'b0;
      have_prev_r <= 1'b0;
      pub_r       <= 1'b0;
      wtot_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sq_x_r      <= sq_x_nxt;
      sq_y_r      <= sq_y_nxt;
      cross_r     <= cross_nxt;
      fc_r        <= fc_nxt;
      cc_r        <= cc_nxt;
      level_r     <= level_nxt;
      was_above_r <= was_above_nxt;
      have_prev_r <= have_prev_nxt;
      pub_r       <= pub_nxt;
      wtot_r      <= wtot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    nn_r       <= nn_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    verdict_r  <= verdict_nxt;
    bal_r      <= bal_nxt;
    ph_r       <= ph_nxt;
    neg_r      <= neg_nxt;
    s_r        <= s_nxt;
    lg_m_r     <= lg_m_nxt;
    lg_acc_r   <= lg_acc_nxt;
    lg_y_r     <= lg_y_nxt;
    lg_i_r     <= lg_i_nxt;
    lg_sel_r   <= lg_sel_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic signed [15:0] xs, ys;
    logic               above;
    logic [15:0]        fc_inc, q16, lv;
    logic [63:0]        d64, u64, rnd;
    logic [33:0]        m2;
    logic [19:0]        acc_new;
    logic [3:0]         p;
    logic signed [20:0] ldiff;
    logic [20:0]        lmag;
    logic [23:0]        qb;
    logic signed [31:0] zc;
    logic [23:0]        zr;
    logic [1:0]         vd;

    xs = in_tdata[15:0];
    ys = in_tdata[31:16];
    above = 1'b0; fc_inc = 16'd0; q16 = 16'd0; lv = 16'd0;
    d64 = 64'd0; u64 = 64'd0; rnd = 64'd0; m2 = 34'd0; acc_new = 20'd0;
    p = 4'd0; ldiff = 21'sd0; lmag = 21'd0; qb = 24'd0; zc = 32'sd0;
    zr = 24'd0; vd = qpwa_pkg::VERDICT_SILENT;

    state_nxt = state_r; launched_nxt = launched_r;
    x_nxt = x_r; y_nxt = y_r; level_nxt = level_r;
    sum_x_nxt = sum_x_r; sum_y_nxt = sum_y_r;
    sq_x_nxt = sq_x_r; sq_y_nxt = sq_y_r; cross_nxt = cross_r;
    fc_nxt = fc_r; cc_nxt = cc_r; was_above_nxt = was_above_r;
    have_prev_nxt = have_prev_r; pub_nxt = pub_r; wtot_nxt = wtot_r;
    nn_nxt = nn_r; wa_nxt = wa_r; wb_nxt = wb_r;
    cx_nxt = cx_r; cy_nxt = cy_r; ax_nxt = ax_r; ay_nxt = ay_r;
    verdict_nxt = verdict_r; bal_nxt = bal_r; ph_nxt = ph_r;
    neg_nxt = neg_r; s_nxt = s_r;
    lg_m_nxt = lg_m_r; lg_acc_nxt = lg_acc_r; lg_y_nxt = lg_y_r;
    lg_i_nxt = lg_i_r; lg_sel_nxt = lg_sel_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;

    mul_req  = '0;
    div_req  = '0;
    sqrt_req = '0;
    cor_req  = '0;

    // operand routing for the shared units
    case (state_r)
      qpwa_pkg::S_SQX: begin mul_req.a = 64'(xm); mul_req.b = 64'(xm); end
      qpwa_pkg::S_SQY: begin mul_req.a = 64'(ym); mul_req.b = 64'(ym); end
      qpwa_pkg::S_SXY: begin
        mul_req.a = 64'(xm); mul_req.b = 64'(ym); mul_req.neg = x_r[15] ^ y_r[15];
      end
      qpwa_pkg::S_NN:  begin mul_req.a = 64'(fc_r); mul_req.b = 64'(fc_r); end
      qpwa_pkg::S_CXD: begin
        div_req.num = {31'd0, mx, 1'b0} + 64'(fc_r);
        div_req.den = {47'd0, fc_r, 1'b0};
      end
      qpwa_pkg::S_CYD: begin
        div_req.num = {31'd0, my, 1'b0} + 64'(fc_r);
        div_req.den = {47'd0, fc_r, 1'b0};
      end
      qpwa_pkg::S_AXA: begin mul_req.a = 64'(fc_r); mul_req.b = 64'(sq_x_r); end
      qpwa_pkg::S_AYA: begin mul_req.a = 64'(fc_r); mul_req.b = 64'(sq_y_r); end
      qpwa_pkg::S_AXB: begin mul_req.a = 64'(mx); mul_req.b = 64'(mx); end
      qpwa_pkg::S_AYB: begin mul_req.a = 64'(my); mul_req.b = 64'(my); end
      qpwa_pkg::S_AXD, qpwa_pkg::S_AYD, qpwa_pkg::S_PHC: begin
        div_req.num = wa_r; div_req.den = 64'(nn_r);
      end
      qpwa_pkg::S_AXS, qpwa_pkg::S_AYS: sqrt_req.v = wa_r;
      qpwa_pkg::S_LGS: begin mul_req.a = 64'(lg_m_r); mul_req.b = 64'(lg_m_r); end
      qpwa_pkg::S_BAL: begin
        ldiff = $signed({1'b0, lg_y_r}) - $signed({1'b0, lg_acc_r});
        lmag  = ldiff[20] ? 21'(-ldiff) : 21'(ldiff);
        mul_req.a = 64'(lmag); mul_req.b = 64'(qpwa_pkg::BAL_K);
      end
      qpwa_pkg::S_PHA: begin
        mul_req.a = 64'(fc_r); mul_req.b = 64'(cmag); mul_req.neg = cross_r[47];
      end
      qpwa_pkg::S_PHB: begin
        mul_req.a = 64'(mx); mul_req.b = 64'(my); mul_req.neg = sum_x_r[31] ^ sum_y_r[31];
      end
      qpwa_pkg::S_PHD: begin mul_req.a = 64'(ax_r); mul_req.b = 64'(ay_r); end
      qpwa_pkg::S_PHE: begin div_req.num = wa_r; div_req.den = wb_r; end
      qpwa_pkg::S_PHF: begin mul_req.a = 64'(s_r); mul_req.b = 64'(s_r); end
      qpwa_pkg::S_PHG: sqrt_req.v = wb_r;
      qpwa_pkg::S_PHH: begin
        cor_req.x0 = $signed({wb_r[19:0], 14'd0});
        cor_req.y0 = $signed({3'd0, s_r, 14'd0});
      end
      default: ;
    endcase

    case (state_r)
      qpwa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          x_nxt = xs;
          y_nxt = ys;
          sum_x_nxt = sum_x_r + {{16{xs[15]}}, xs};
          sum_y_nxt = sum_y_r + {{16{ys[15]}}, ys};
          above = xs > level_r;
          if (have_prev_r && (above != was_above_r) && (cc_r != 16'hFFFF))
            cc_nxt = cc_r + 16'd1;
          was_above_nxt = above;
          have_prev_nxt = 1'b1;
          fc_inc = (fc_r != 16'hFFFF) ? fc_r + 16'd1 : fc_r;
          fc_nxt = fc_inc;
          pub_nxt = (fc_inc >= wl_r) || (fc_inc == 16'hFFFF);
          state_nxt = qpwa_pkg::S_SQX;
        end
      end

      qpwa_pkg::S_VERD: begin
        if (ax_r < sf_r && ay_r < sf_r) vd = qpwa_pkg::VERDICT_SILENT;
        else if (cc_r < mht_r) vd = qpwa_pkg::VERDICT_SLOW;
        else vd = qpwa_pkg::VERDICT_MEASURED;
        verdict_nxt = vd;
        bal_nxt = 16'd0;
        ph_nxt  = 16'd0;
        if (vd != qpwa_pkg::VERDICT_MEASURED) begin
          state_nxt = qpwa_pkg::S_FIN;
        end else if (ax_r == 16'd0 || ay_r == 16'd0) begin
          // a leg dead: balance pinned toward the live leg (zero if both dead), phase stays zero
          if (ax_r == 16'd0 && ay_r != 16'd0) bal_nxt = 16'h7FFF;
          else if (ay_r == 16'd0 && ax_r != 16'd0) bal_nxt = 16'h8000;
          state_nxt = qpwa_pkg::S_FIN;
        end else begin
          lg_sel_nxt = 1'b1;
          state_nxt  = qpwa_pkg::S_LGI;
        end
      end

      qpwa_pkg::S_LGI: begin
        lv = lg_sel_r ? ay_r : ax_r;
        for (int i = 0; i < 16; i++) if (lv[i]) p = 4'(i);
        lg_m_nxt   = {16'd0, lv} << (5'd30 - {1'b0, p});
        lg_acc_nxt = {p, 16'd0};
        lg_i_nxt   = 4'd0;
        state_nxt  = qpwa_pkg::S_LGS;
      end

      qpwa_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, ph_r, bal_r, verdict_r, wtot_r + 32'd1,
                           cc_r, ay_r, ax_r, cy_r, cx_r};
          wtot_nxt  = wtot_r + 32'd1;
          level_nxt = cx_r;
          sum_x_nxt = 32'd0; sum_y_nxt = 32'd0;
          sq_x_nxt = 48'd0; sq_y_nxt = 48'd0; cross_nxt = 48'd0;
          fc_nxt = 16'd0; cc_nxt = 16'd0; have_prev_nxt = 1'b0;
          state_nxt = qpwa_pkg::S_IDLE;
        end
      end

      default: begin
        // unit states: launch once, then wait for the done pulse
        if (!launched_r) begin
          launched_nxt = 1'b1;
          case (state_r)
            qpwa_pkg::S_CXD, qpwa_pkg::S_CYD, qpwa_pkg::S_AXD, qpwa_pkg::S_AYD,
            qpwa_pkg::S_PHC, qpwa_pkg::S_PHE: div_req.start = 1'b1;
            qpwa_pkg::S_AXS, qpwa_pkg::S_AYS, qpwa_pkg::S_PHG: sqrt_req.start = 1'b1;
            qpwa_pkg::S_PHH: cor_req.start = 1'b1;
            default: mul_req.start = 1'b1;
          endcase
        end else begin
          case (state_r)
            qpwa_pkg::S_SQX: if (mul_done) begin
              launched_nxt = 1'b0; sq_x_nxt = sq_x_r + mul_res[47:0];
              state_nxt = qpwa_pkg::S_SQY;
            end
            qpwa_pkg::S_SQY: if (mul_done) begin
              launched_nxt = 1'b0; sq_y_nxt = sq_y_r + mul_res[47:0];
              state_nxt = qpwa_pkg::S_SXY;
            end
            qpwa_pkg::S_SXY: if (mul_done) begin
              launched_nxt = 1'b0; cross_nxt = cross_r + mul_res[47:0];
              state_nxt = pub_r ? qpwa_pkg::S_NN : qpwa_pkg::S_IDLE;
            end
            qpwa_pkg::S_NN: if (mul_done) begin
              launched_nxt = 1'b0; nn_nxt = mul_res[31:0];
              state_nxt = qpwa_pkg::S_CXD;
            end
            qpwa_pkg::S_CXD: if (div_done) begin
              launched_nxt = 1'b0; q16 = div_res[15:0];
              cx_nxt = sum_x_r[31] ? (16'd0 - q16) : q16;
              state_nxt = qpwa_pkg::S_CYD;
            end
            qpwa_pkg::S_CYD: if (div_done) begin
              launched_nxt = 1'b0; q16 = div_res[15:0];
              cy_nxt = sum_y_r[31] ? (16'd0 - q16) : q16;
              state_nxt = qpwa_pkg::S_AXA;
            end
            qpwa_pkg::S_AXA, qpwa_pkg::S_AYA: if (mul_done) begin
              launched_nxt = 1'b0; wa_nxt = mul_res;
              state_nxt = (state_r == qpwa_pkg::S_AXA) ? qpwa_pkg::S_AXB : qpwa_pkg::S_AYB;
            end
            qpwa_pkg::S_AXB, qpwa_pkg::S_AYB: if (mul_done) begin
              launched_nxt = 1'b0;
              d64 = (wa_r > mul_res) ? (wa_r - mul_res) : 64'd0;
              if (d64[63]) d64 = 64'h7FFF_FFFF_FFFF_FFFF;
              wa_nxt = {d64[62:0], 1'b0};
              state_nxt = (state_r == qpwa_pkg::S_AXB) ? qpwa_pkg::S_AXD : qpwa_pkg::S_AYD;
            end
            qpwa_pkg::S_AXD, qpwa_pkg::S_AYD: if (div_done) begin
              launched_nxt = 1'b0; wa_nxt = div_res;
              state_nxt = (state_r == qpwa_pkg::S_AXD) ? qpwa_pkg::S_AXS : qpwa_pkg::S_AYS;
            end
            qpwa_pkg::S_AXS: if (sqrt_done) begin
              launched_nxt = 1'b0;
              ax_nxt = (sqrt_res > 32'hFFFF) ? 16'hFFFF : sqrt_res[15:0];
              state_nxt = qpwa_pkg::S_AYA;
            end
            qpwa_pkg::S_AYS: if (sqrt_done) begin
              launched_nxt = 1'b0;
              ay_nxt = (sqrt_res > 32'hFFFF) ? 16'hFFFF : sqrt_res[15:0];
              state_nxt = qpwa_pkg::S_VERD;
            end
            qpwa_pkg::S_LGS: if (mul_done) begin
              launched_nxt = 1'b0;
              m2 = mul_res[63:30];
              acc_new = lg_acc_r;
              if (m2[31]) begin
                lg_m_nxt = m2[32:1];
                acc_new = lg_acc_r | (20'd1 << (4'd15 - lg_i_r));
              end else begin
                lg_m_nxt = m2[31:0];
              end
              lg_acc_nxt = acc_new;
              lg_i_nxt   = lg_i_r + 4'd1;
              if (lg_i_r == 4'd15) begin
                if (lg_sel_r) begin
                  lg_y_nxt   = acc_new;
                  lg_sel_nxt = 1'b0;
                  state_nxt  = qpwa_pkg::S_LGI;
                end else begin
                  state_nxt  = qpwa_pkg::S_BAL;
                end
              end
            end
            qpwa_pkg::S_BAL: if (mul_done) begin
              launched_nxt = 1'b0;
              rnd = mul_res + 64'h80_0000;
              qb  = rnd[47:24];
              if (ldiff[20]) bal_nxt = (qb > 24'd32768) ? 16'h8000 : (16'd0 - qb[15:0]);
              else bal_nxt = (qb > 24'd32767) ? 16'h7FFF : qb[15:0];
              state_nxt = qpwa_pkg::S_PHA;
            end
            qpwa_pkg::S_PHA: if (mul_done) begin
              launched_nxt = 1'b0; wa_nxt = mul_res;
              state_nxt = qpwa_pkg::S_PHB;
            end
            qpwa_pkg::S_PHB: if (mul_done) begin
              launched_nxt = 1'b0;
              u64 = wa_r - mul_res;
              neg_nxt = u64[63];
              wa_nxt  = u64[63] ? (64'd0 - u64) : u64;
              state_nxt = qpwa_pkg::S_PHC;
            end
            qpwa_pkg::S_PHC: if (div_done) begin
              launched_nxt = 1'b0;
              d64 = (div_res > 64'h8000_0000) ? 64'h8000_0000 : div_res;
              wa_nxt = {d64[46:0], 17'd0};
              state_nxt = qpwa_pkg::S_PHD;
            end
            qpwa_pkg::S_PHD: if (mul_done) begin
              launched_nxt = 1'b0; wb_nxt = mul_res;
              state_nxt = qpwa_pkg::S_PHE;
            end
            qpwa_pkg::S_PHE: if (div_done) begin
              launched_nxt = 1'b0;
              s_nxt = (div_res > 64'd65536) ? 17'h10000 : div_res[16:0];
              state_nxt = qpwa_pkg::S_PHF;
            end
            qpwa_pkg::S_PHF: if (mul_done) begin
              launched_nxt = 1'b0; wb_nxt = 64'h1_0000_0000 - mul_res;
              state_nxt = qpwa_pkg::S_PHG;
            end
            qpwa_pkg::S_PHG: if (sqrt_done) begin
              launched_nxt = 1'b0; wb_nxt = 64'(sqrt_res);
              state_nxt = qpwa_pkg::S_PHH;
            end
            qpwa_pkg::S_PHH: if (cor_done) begin
              launched_nxt = 1'b0;
              zc = (cor_angle < 32'sd0) ? 32'sd0 : cor_angle;
              zr = 24'((zc + 32'sd128) >>> 8);
              if (zr > 24'(qpwa_pkg::PHASE_MAX)) zr = 24'(qpwa_pkg::PHASE_MAX);
              ph_nxt = neg_r ? (16'd0 - zr[15:0]) : zr[15:0];
              state_nxt = qpwa_pkg::S_FIN;
            end
            default: state_nxt = qpwa_pkg::S_IDLE;
          endcase
        end
      end
    endcase
  end
endmodule
`default_nettype wire

### sv/qpwa_checker.sv
// Port-level checks for the quadrature pair window analyser, bound to the top.
// Depends on quadrature_pair_window_analyser_unit port names.
`timescale 1ns / 1ps
`default_nettype none
module qpwa_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [151:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[113:112] != 2'd3)
    else $error("bad verdict");

  a_unmeasured_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[113:112] != 2'd2 |-> out_tdata[145:114] == 32'd0)
    else $error("balance or phase set on unmeasured reading");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[145:130]) <= 16'sd23040) &&
                   ($signed(out_tdata[145:130]) >= -16'sd23040))
    else $error("phase out of range");
endmodule

bind quadrature_pair_window_analyser_unit qpwa_checker u_qpwa_checker (.*);
`default_nettype wire

### bench/quadrature_pair_window_analyser_unit_test.sv
// Self-checking bench for quadrature_pair_window_analyser_unit: a bit-exact window
// predictor runs on every accepted frame and each reading is checked field by field.
// Depends on qpwa_pkg and the unit top level.
`timescale 1ns / 1ps
module quadrature_pair_window_analyser_unit_test;

  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] phase;
    logic [15:0] balance;
    logic [1:0]  verdict;
    logic [31:0] window_no;
    logic [15:0] half_turns;
    logic [15:0] amp_y;
    logic [15:0] amp_x;
    logic [15:0] cy;
    logic [15:0] cx;
  } reading_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [31:0]  in_tdata;           // sample_x[15:0], sample_y[31:16]
  logic         out_tvalid, out_tready;
  logic [qpwa_pkg::OUT_W-1:0] out_tdata;  // see reading_t, cx in the lowest bits
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  quadrature_pair_window_analyser_unit i_dut (.*);

  // window statistics shadow
  bit [15:0] win_len = 16'd4096, floor_amp = 16'd328, least_turns = 16'd4;
  bit [31:0] acc_x, acc_y, tot_windows;
  bit [47:0] acc_sq_x, acc_sq_y, acc_xy;
  bit [15:0] frames_in_win, turns;
  logic signed [15:0] level = 16'sd0;
  bit was_above, have_prev;

  logic [31:0] frames_q[$];
  reading_t    readings_q[$];
  int          errors;
  bit          calm_in, calm_out;
  int          gap_in, gap_out;

  function automatic void add_frame(logic [31:0] f);
    frames_q = {frames_q, f};
  endfunction

  function automatic bit [63:0] isqrt64(bit [63:0] v);
    bit [63:0] res = 0, b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [15:0] peak_amp(bit [47:0] sq, bit [31:0] s, bit [63:0] n);
    longint sv = $signed(s);
    bit [63:0] m, a, b, d, r;
    m = sv < 0 ? -sv : sv;
    a = n * {16'd0, sq};
    b = m * m;
    d = a > b ? a - b : 0;
    if (d[63]) d = 64'h7FFF_FFFF_FFFF_FFFF;
    r = isqrt64((2 * d) / (n * n));
    return r > 64'hFFFF ? 16'hFFFF : r[15:0];
  endfunction

  function automatic longint log2_q16(bit [63:0] v);
    int p = 0;
    bit [63:0] m;
    longint r;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = p <= 30 ? v << (30 - p) : v >> (p - 30);
    r = longint'(p) << 16;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        r |= longint'(1) << (15 - i);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] centre_of(bit [31:0] s, bit [63:0] n);
    longint sv = $signed(s);
    bit [63:0] m, q;
    m = sv < 0 ? -sv : sv;
    q = (m * 2 + n) / (2 * n);
    return sv < 0 ? 16'(-q) : q[15:0];
  endfunction

  function automatic longint asin_q88(bit [63:0] s);
    longint x, y, z = 0, nx;
    longint atan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    x = longint'(isqrt64((64'd1 << 32) - s * s)) << 14;
    y = longint'(s) << 14;
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_q16[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q16[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    z = (z + 128) >>> 8;
    return z > 23040 ? 23040 : z;
  endfunction

  function automatic reading_t close_window();
    reading_t r;
    bit [63:0] n = frames_in_win, u, cq, s, sx64, sy64, xy64, mg;
    longint bal = 0, ph = 0, p;
    r = '0;
    r.cx = centre_of(acc_x, n);
    r.cy = centre_of(acc_y, n);
    r.amp_x = peak_amp(acc_sq_x, acc_x, n);
    r.amp_y = peak_amp(acc_sq_y, acc_y, n);
    tot_windows++;
    if (r.amp_x < floor_amp && r.amp_y < floor_amp) r.verdict = qpwa_pkg::VERDICT_SILENT;
    else if (turns < least_turns) r.verdict = qpwa_pkg::VERDICT_SLOW;
    else begin
      r.verdict = qpwa_pkg::VERDICT_MEASURED;
      if (r.amp_x == 0 && r.amp_y == 0) bal = 0;
      else if (r.amp_x == 0) bal = 32767;
      else if (r.amp_y == 0) bal = -32768;
      else begin
        p = (log2_q16(r.amp_y) - log2_q16(r.amp_x)) * 394566;
        bal = p >= 0 ? (p + (1 << 23)) >>> 24 : -((-p + (1 << 23)) >>> 24);
        if (bal > 32767) bal = 32767;
        if (bal < -32768) bal = -32768;
      end
      if (r.amp_x != 0 && r.amp_y != 0) begin
        xy64 = longint'($signed(acc_xy));
        sx64 = longint'($signed(acc_x));
        sy64 = longint'($signed(acc_y));
        u = n * xy64 - sx64 * sy64;
        mg = u[63] ? -u : u;
        cq = mg / (n * n);
        if (cq > (64'd1 << 31)) cq = 64'd1 << 31;
        s = (cq << 17) / ({48'd0, r.amp_x} * {48'd0, r.amp_y});
        if (s > 65536) s = 65536;
        ph = asin_q88(s);
        if (u[63]) ph = -ph;
      end
    end
    r.half_turns = turns;
    r.window_no = tot_windows;
    r.balance = 16'(bal);
    r.phase = 16'(ph);
    level = r.cx;
    acc_x = 0; acc_y = 0; acc_sq_x = 0; acc_sq_y = 0; acc_xy = 0;
    frames_in_win = 0;
    turns = 0;
    have_prev = 0;
    return r;
  endfunction

  function automatic void fold_frame(logic [31:0] d);
    longint x = $signed(d[15:0]), y = $signed(d[31:16]);
    bit above;
    acc_x += 32'(x);
    acc_y += 32'(y);
    acc_sq_x += 48'(x * x);
    acc_sq_y += 48'(y * y);
    acc_xy += 48'(x * y);
    above = x > longint'(level);
    if (have_prev && above != was_above && turns != 16'hFFFF) turns++;
    was_above = above;
    have_prev = 1;
    if (frames_in_win != 16'hFFFF) frames_in_win++;
    if (frames_in_win >= win_len || frames_in_win == 16'hFFFF)
      readings_q = {readings_q, close_window()};
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  function automatic int pick_gap(bit calm);
    int r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // frame driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= 0;
      gap_in <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_tvalid <= 0;
      end else if (frames_q.size() != 0) begin
        in_tdata <= frames_q.pop_front();
        in_tvalid <= 1;
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
        gap_in <= pick_gap(calm_in);
      end else in_tvalid <= 0;
    end
  end

  // result side: backpressure, prediction on input transfer, checking on output transfer
  always @(posedge clk) begin
    reading_t got, exp;
    if (!rst_n) begin
      out_tready <= 0;
      gap_out <= 0;
    end else begin
      if (in_tvalid && in_tready) fold_frame(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (readings_q.size() == 0) begin
          $error("reading with no expectation pending");
          errors++;
        end else begin
          exp = readings_q.pop_front();
          check_field("mean_x", exp.cx, got.cx);
          check_field("mean_y", exp.cy, got.cy);
          check_field("peak_x", exp.amp_x, got.amp_x);
          check_field("peak_y", exp.amp_y, got.amp_y);
          check_field("half_turns", exp.half_turns, got.half_turns);
          check_field("window_number", exp.window_no, got.window_no);
          check_field("verdict", exp.verdict, got.verdict);
          check_field("level_ratio", exp.balance, got.balance);
          check_field("skew_angle", exp.phase, got.phase);
        end
      end
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_tready <= 0;
      end else begin
        if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
        gap_out <= pick_gap(calm_out);
        out_tready <= 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      qpwa_pkg::REG_WINDOW_LENGTH:  win_len = val;
      qpwa_pkg::REG_SILENCE_FLOOR:  floor_amp = val;
      qpwa_pkg::REG_MIN_HALF_TURNS: least_turns = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // drain everything, then let a non-closing frame finish before touching registers
  task automatic settle();
    wait (frames_q.size() == 0 && !in_tvalid);
    wait (readings_q.size() == 0);
    repeat (2000) @(posedge clk);
  endtask

  task automatic setup(int wl, int fl, int mt);
    settle();
    write_reg(qpwa_pkg::REG_WINDOW_LENGTH, 16'(wl));
    write_reg(qpwa_pkg::REG_SILENCE_FLOOR, 16'(fl));
    write_reg(qpwa_pkg::REG_MIN_HALF_TURNS, 16'(mt));
  endtask

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // sine-like quadrature pair with random levels, or plain noise
  task automatic queue_pair_run(int count);
    longint wave[8] = '{0, 23170, 32767, 23170, 0, -23170, -32767, -23170};
    longint ax, ay, dx, dy;
    int k, ph, step;
    ax = $urandom_range(0, 32767);
    ay = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : ax;
    dx = $signed(16'($urandom)) >>> $urandom_range(3, 15);
    dy = $signed(16'($urandom)) >>> $urandom_range(3, 15);
    ph = $urandom_range(1, 3) + ($urandom_range(0, 1) ? 4 : 0);
    step = $urandom_range(1, 3);
    k = $urandom_range(0, 7);
    repeat (count) begin
      if ($urandom_range(0, 9) < 2)
        add_frame($urandom);
      else
        add_frame({sat16(dy + ay * wave[(k + ph) % 8] / 32768),
                   sat16(dx + ax * wave[k % 8] / 32768)});
      k += step;
    end
  endtask

  initial begin
    int wl;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // window length zero: a reading per frame, both amplitudes zero
    setup(0, 0, 0);
    add_frame({16'h8000, 16'h7FFF});
    add_frame({16'h7FFF, 16'h8000});
    // x flat, y moving: balance saturates high; then the mirror case
    setup(4, 0, 0);
    add_frame({16'h8000, 16'h1234});
    add_frame({16'h7FFF, 16'h1234});
    add_frame({16'h8000, 16'h1234});
    add_frame({16'h7FFF, 16'h1234});
    add_frame({16'h0000, 16'h7FFF});
    add_frame({16'h0000, 16'h8000});
    add_frame({16'h0000, 16'h7FFF});
    add_frame({16'h0000, 16'hFFFF});
    // sine-like runs against a floor near full scale, an unreachable half-turn minimum, then a low one
    setup(8, 46341, 0);
    queue_pair_run(8);
    setup(8, 0, 65535);
    queue_pair_run(8);
    setup(8, 0, 2);
    queue_pair_run(8);
    // longest window, cut short by a later length write
    setup(65535, 328, 4);
    queue_pair_run(3);
    setup(2, 328, 4);
    add_frame(32'h0);

    repeat (12) begin
      wl = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
      setup(wl,
            $urandom_range(0, 5) == 0 ? 46341 : $urandom_range(0, 2000),
            $urandom_range(0, 7) == 0 ? 65535 : $urandom_range(0, 8));
      repeat (4) queue_pair_run($urandom_range(5, 15));
    end

    settle();
    if (errors == 0) $display("quadrature_pair_window_analyser_unit: match");
    else $display("quadrature_pair_window_analyser_unit: mismatch");
    $finish;
  end

  initial begin
    #50ms;
    $display("quadrature_pair_window_analyser_unit: mismatch");
    $finish;
  end

endmodule

### filelist.f
sv/qpwa_pkg.sv
sv/qpwa_mul.sv
sv/qpwa_div.sv
sv/qpwa_sqrt.sv
sv/qpwa_cordic.sv
sv/quadrature_pair_window_analyser_unit.sv
sv/qpwa_checker.sv
bench/quadrature_pair_window_analyser_unit_test.sv
